FILE: sv/qas_pkg.sv
package qas_pkg;

  // window geometry
  localparam int unsigned WIN_DEPTH = 4;
  localparam int unsigned FILL_W    = 3;

  // register indexes
  localparam logic CFG_MAX_ARGS   = 1'b0;
  localparam logic CFG_MAX_LENGTH = 1'b1;

  // register reset values
  localparam logic [6:0]  MAX_ARGS_RST   = 7'd20;
  localparam logic [15:0] MAX_LENGTH_RST = 16'd2000;

  // characters of interest
  localparam logic [7:0] CH_BSLASH = 8'h5c;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;

  // per-line context carried from one decision to the next
  typedef struct packed {
    logic [1:0] skip_left;
    logic       in_dquote;
    logic       in_gap_run;
    logic       stopped;
    logic [6:0] args;
    logic       begin_pending;
  } qas_ctx_t;

  // one decided byte
  typedef struct packed {
    logic [7:0] char_out;
    logic       is_gap;
    logic       begins_arg;
    logic [6:0] arg_number;
  } qas_res_t;

endpackage

FILE: sv/qas_decide.sv
module qas_decide (
  input  logic [3:0][7:0]                win,
  input  logic [qas_pkg::FILL_W-1:0]     fill,
  input  qas_pkg::qas_ctx_t              ctx,
  input  logic [6:0]                     max_args,
  output qas_pkg::qas_res_t              res,
  output qas_pkg::qas_ctx_t              ctx_nxt
);

  logic [3:0] vld;
  logic       blank0;
  logic       blank1;
  logic       quote1;
  logic       next_arg;
  logic       at_limit;

  // window slot k holds a byte only below the fill count
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      vld[k] = fill > k[qas_pkg::FILL_W-1:0];
    end
  end

  assign blank0 = (win[0] == qas_pkg::CH_SPACE) || (win[0] == qas_pkg::CH_TAB);
  assign blank1 = vld[1] && ((win[1] == qas_pkg::CH_SPACE) || (win[1] == qas_pkg::CH_TAB));
  assign quote1 = vld[1] && ((win[1] == qas_pkg::CH_SQUOTE) || (win[1] == qas_pkg::CH_DQUOTE));

  // argument count has reached max_args minus two
  assign at_limit = ({1'b0, ctx.args} + 8'd2) >= {1'b0, max_args};

  // head byte decision
  always_comb begin
    ctx_nxt      = ctx;
    res.char_out = win[0];
    res.is_gap   = 1'b0;
    next_arg     = 1'b0;
    if (ctx.skip_left != 2'd0) begin
      ctx_nxt.skip_left = ctx.skip_left - 2'd1;
    end else if (ctx.in_gap_run) begin
      res.char_out       = 8'd0;
      res.is_gap         = 1'b1;
      ctx_nxt.in_gap_run = blank1;
      next_arg           = !blank1 && (fill > 3'd1);
    end else if (ctx.stopped || (max_args <= 7'd1)) begin
      // pass unchanged
    end else if ((win[0] == qas_pkg::CH_BSLASH) && quote1) begin
      ctx_nxt.skip_left = 2'd1;
    end else if ((win[0] == qas_pkg::CH_SQUOTE) && vld[1] && (win[1] == qas_pkg::CH_BSLASH)
                 && vld[3] && (win[3] == qas_pkg::CH_SQUOTE)) begin
      ctx_nxt.skip_left = 2'd3;
    end else if ((win[0] == qas_pkg::CH_SQUOTE) && vld[2]
                 && (win[2] == qas_pkg::CH_SQUOTE)) begin
      ctx_nxt.skip_left = 2'd2;
    end else if (win[0] == qas_pkg::CH_DQUOTE) begin
      ctx_nxt.in_dquote = !ctx.in_dquote;
    end else if (ctx.in_dquote) begin
      // protected
    end else if (blank0) begin
      if (at_limit) begin
        ctx_nxt.stopped = 1'b1;
      end else begin
        res.char_out       = 8'd0;
        res.is_gap         = 1'b1;
        ctx_nxt.in_gap_run = blank1;
        next_arg           = !blank1 && (fill > 3'd1);
      end
    end
    res.begins_arg        = ctx.begin_pending;
    res.arg_number        = ctx.args;
    ctx_nxt.begin_pending = next_arg;
    ctx_nxt.args          = ctx.args + {6'd0, next_arg};
  end

endmodule

FILE: sv/quoted_argument_splitter.sv
// channel  | handshake                 | payload
// ---------+---------------------------+----------------------------------------------
// in       | in_valid / in_ready       | in_char_in, in_line_end
// out      | out_valid / out_ready     | out_char_out, out_is_gap, out_begins_arg,
//          |                           | out_arg_number, out_final_out, out_arg_total
// cfg      | cfg_we (no wait)          | cfg_index, cfg_data
//
// one byte per cycle in mid-line: each byte enters the four-byte window and the head
// byte is decided from the registered window into the output register.
// a line end flushes the window at one result per cycle while the output is free (up to four
// results, or one terminator), so the request after a line end waits until the flush ends.
// a stalled output register holds back decisions, and input once the window is full.
// synchronous active-low reset; every line end returns the line state to reset.
module quoted_argument_splitter #(
  parameter int unsigned POSITION_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_char_in,
  input  logic        in_line_end,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_char_out,
  output logic        out_is_gap,
  output logic        out_begins_arg,
  output logic [6:0]  out_arg_number,
  output logic        out_final_out,
  output logic [6:0]  out_arg_total,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int unsigned CW = ((POSITION_BITS > 16) ? POSITION_BITS : 16) + 1;
  localparam logic [POSITION_BITS-1:0] POS_TOP = {POSITION_BITS{1'b1}};
  localparam qas_pkg::qas_ctx_t CTX_RST = '{skip_left: 2'd0, in_dquote: 1'b0,
                                            in_gap_run: 1'b0, stopped: 1'b0,
                                            args: 7'd0, begin_pending: 1'b1};

  logic [6:0]                   max_args_r;
  logic [15:0]                  max_length_r;
  logic [3:0][7:0]              win_r, win_nxt, win_shift;
  logic [qas_pkg::FILL_W-1:0]   fill_r, fill_nxt, fill_mid;
  logic [POSITION_BITS-1:0]     pos_r, pos_nxt;
  logic                         end_r, end_nxt;
  qas_pkg::qas_ctx_t            ctx_r, ctx_nxt, ctx_dec;
  qas_pkg::qas_res_t            res;

  logic        out_valid_r;
  logic [7:0]  char_r;
  logic        gap_r, begins_r, final_r;
  logic [6:0]  argnum_r, total_r;

  logic out_free, dec, term, accept, kept, last;
  logic [6:0] total_val;

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_args_r   <= qas_pkg::MAX_ARGS_RST;
      max_length_r <= qas_pkg::MAX_LENGTH_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        qas_pkg::CFG_MAX_ARGS:   max_args_r   <= cfg_data[6:0];
        qas_pkg::CFG_MAX_LENGTH: max_length_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // head byte decision
  qas_decide u_decide (
    .win      (win_r),
    .fill     (fill_r),
    .ctx      (ctx_r),
    .max_args (max_args_r),
    .res      (res),
    .ctx_nxt  (ctx_dec)
  );

  // decision, terminator and request acceptance
  assign out_free = !out_valid_r || out_ready;
  assign dec      = out_free && ((fill_r == 3'd4) || (end_r && (fill_r != 3'd0)));
  assign term     = out_free && end_r && (fill_r == 3'd0);
  assign last     = (dec && end_r && (fill_r == 3'd1)) || term;
  assign in_ready = !end_r && ((fill_r != 3'd4) || dec);
  assign accept   = in_valid && in_ready;
  assign kept     = (pos_r != POS_TOP) &&
                    ((CW'(pos_r) + CW'(1)) < CW'(max_length_r));

  // argument count reported on the last result
  assign total_val = (max_args_r <= 7'd1) ? 7'd1
                   : (term ? ctx_r.args + 7'd1 : ctx_dec.args + 7'd1);

  // window shift and insertion
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      win_shift[k] = dec ? win_r[k+1] : win_r[k];
    end
    win_shift[3] = dec ? 8'd0 : win_r[3];
    fill_mid     = fill_r - {2'd0, dec};
    win_nxt      = win_shift;
    fill_nxt     = fill_mid;
    pos_nxt      = pos_r;
    end_nxt      = end_r;
    ctx_nxt      = dec ? ctx_dec : ctx_r;
    if (accept) begin
      if (kept) begin
        win_nxt[fill_mid[1:0]] = in_char_in;
        fill_nxt               = fill_mid + 3'd1;
      end
      if (pos_r != POS_TOP) begin
        pos_nxt = pos_r + POSITION_BITS'(1);
      end
      end_nxt = in_line_end;
    end
    if (last) begin
      win_nxt  = '0;
      fill_nxt = '0;
      pos_nxt  = '0;
      end_nxt  = 1'b0;
      ctx_nxt  = CTX_RST;
    end
  end

  // line state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r  <= '0;
      fill_r <= '0;
      pos_r  <= '0;
      end_r  <= 1'b0;
      ctx_r  <= CTX_RST;
    end else begin
      win_r  <= win_nxt;
      fill_r <= fill_nxt;
      pos_r  <= pos_nxt;
      end_r  <= end_nxt;
      ctx_r  <= ctx_nxt;
    end
  end

  // output register valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (dec || term) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // output register payload
  always_ff @(posedge clk) begin
    if (dec) begin
      char_r   <= res.char_out;
      gap_r    <= res.is_gap;
      begins_r <= res.begins_arg;
      argnum_r <= res.arg_number;
      final_r  <= last;
      total_r  <= last ? total_val : 7'd0;
    end else if (term) begin
      char_r   <= 8'd0;
      gap_r    <= 1'b0;
      begins_r <= 1'b0;
      argnum_r <= ctx_r.args;
      final_r  <= 1'b1;
      total_r  <= total_val;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_char_out   = char_r;
  assign out_is_gap     = gap_r;
  assign out_begins_arg = begins_r;
  assign out_arg_number = argnum_r;
  assign out_final_out  = final_r;
  assign out_arg_total  = total_r;

  // window never overfills
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= 3'd4)
    else $error("window fill above depth");

  // a line end holds off the next request
  a_end_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_line_end) |=> !in_ready)
    else $error("request taken during line flush");

  // the last result leaves a clean line state behind
  a_final_clear: assert property (@(posedge clk) disable iff (!rst_n)
    last |=> (fill_r == 3'd0) && !end_r && (ctx_r.args == 7'd0) && out_final_out)
    else $error("line state not cleared after last result");

endmodule
